[hdl/dht_pkg.sv]
package dht_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W     = 5;
    localparam int KEY_W      = 31;
    localparam int MODE_W     = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd11;
    localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_KEY   = 2'd1,
        ST_TOMB  = 2'd2,
        ST_SPARE = 2'd3
    } status_t;

    // Request handed from the front end to the probe engine
    typedef struct packed {
        mode_t             mode;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W:0]   size;
        logic [SLOT_W-1:0] home;
        logic [3:0]        stride;
    } job_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_MOD,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_PROBE,
        BE_CHECK,
        BE_DONE
    } be_state_t;

endpackage

[hdl/dht_front.sv]
module dht_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dht_pkg::MODE_W-1:0]      mode,
    input  logic [dht_pkg::KEY_W-1:0]       key,
    input  logic [dht_pkg::SIZE_W-1:0]      table_size,
    output logic                            job_valid,
    input  logic                            job_full,
    output dht_pkg::job_t                   job
);

    localparam int REM_W = dht_pkg::SLOT_W + 1;
    localparam int BIT_CNT_W = $clog2(dht_pkg::KEY_W + 1);

    dht_pkg::fe_state_t state_reg, state_next;
    logic [dht_pkg::KEY_W-1:0] key_reg, key_next;
    logic [dht_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [REM_W-1:0] size_reg, size_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [REM_W-1:0] eff_size;
    logic [REM_W:0] shifted;

    // Clamp the configured size into the supported range
    always_comb
    begin
        if (table_size < 5'd2)
            eff_size = REM_W'(2);
        else if (table_size > dht_pkg::SIZE_W'(dht_pkg::MAX_SLOTS))
            eff_size = REM_W'(dht_pkg::MAX_SLOTS);
        else
            eff_size = table_size[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dht_pkg::FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        mode_reg <= mode_next;
        size_reg <= size_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
    end

    // Restoring remainder, one key bit per cycle from the top
    assign shifted = {rem_reg, key_reg[bit_reg[BIT_CNT_W-1:0] - BIT_CNT_W'(1)]};

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        mode_next  = mode_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        in_stall   = 1'b1;
        job_valid  = 1'b0;
        job.mode   = dht_pkg::mode_t'(mode_reg);
        job.key    = key_reg;
        job.size   = size_reg;
        job.home   = rem_reg[dht_pkg::SLOT_W-1:0];
        job.stride = 4'(5'd8 - {2'b00, key_reg[2:0]});
        unique case (state_reg)
            dht_pkg::FE_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    key_next   = key;
                    mode_next  = mode;
                    size_next  = eff_size;
                    rem_next   = '0;
                    bit_next   = BIT_CNT_W'(dht_pkg::KEY_W);
                    state_next = dht_pkg::FE_MOD;
                end
            end
            dht_pkg::FE_MOD:
            begin
                if (shifted >= {1'b0, size_reg})
                    rem_next = REM_W'(shifted - {1'b0, size_reg});
                else
                    rem_next = shifted[REM_W-1:0];
                bit_next = bit_reg - BIT_CNT_W'(1);
                if (bit_reg == BIT_CNT_W'(1))
                    state_next = dht_pkg::FE_PUSH;
            end
            dht_pkg::FE_PUSH:
            begin
                job_valid = !job_full;
                if (!job_full)
                    state_next = dht_pkg::FE_IDLE;
            end
            default:
            begin
                state_next = dht_pkg::FE_IDLE;
            end
        endcase
    end

endmodule

[hdl/dht_queue.sv]
module dht_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dht_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dht_pkg::job_t pop_data
);

    localparam int PTR_W = $clog2(dht_pkg::QUEUE_DEPTH);

    dht_pkg::job_t entry_reg [dht_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0] count_reg;

    assign full      = (count_reg == (PTR_W+1)'(dht_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + PTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

[hdl/dht_back.sv]
module dht_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_ready,
    input  dht_pkg::job_t                 job,
    output logic                          job_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [dht_pkg::SLOT_W-1:0]    slot
);

    localparam int SW = dht_pkg::SLOT_W;

    dht_pkg::be_state_t state_reg, state_next;
    dht_pkg::job_t job_reg, job_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [SW:0] cnt_reg, cnt_next;
    logic ok_reg, ok_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [dht_pkg::MAX_SLOTS-1:0] used_reg, used_next;
    logic [dht_pkg::MAX_SLOTS-1:0] tomb_reg, tomb_next;
    logic [dht_pkg::KEY_W-1:0] key_mem [dht_pkg::MAX_SLOTS];
    logic [dht_pkg::KEY_W-1:0] rd_key_reg;
    logic key_we;
    logic [SW+4:0] step_sum;
    logic [SW:0] step_red;
    dht_pkg::status_t st;

    assign out_valid = (state_reg == dht_pkg::BE_DONE);
    assign ok = ok_reg;
    assign slot = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dht_pkg::BE_IDLE;
            used_reg  <= '0;
            tomb_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            tomb_reg  <= tomb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        pos_reg    <= pos_next;
        cnt_reg    <= cnt_next;
        ok_reg     <= ok_next;
        slot_reg   <= slot_next;
        rd_key_reg <= key_mem[pos_reg];
        if (key_we)
            key_mem[pos_reg] <= job_reg.key;
    end

    // Next probe: pos + stride, stride at most 8 and size at least 2, so up to four subtracts
    assign step_sum = (SW+5)'(pos_reg) + (SW+5)'(job_reg.stride);
    always_comb
    begin
        logic [SW+4:0] t;
        t = step_sum;
        for (int n = 0; n < 4; n++)
        begin
            if (t >= (SW+5)'(job_reg.size))
                t = t - (SW+5)'(job_reg.size);
        end
        step_red = t[SW:0];
    end

    always_comb
    begin
        if (used_reg[pos_reg])
            st = dht_pkg::ST_KEY;
        else if (tomb_reg[pos_reg])
            st = dht_pkg::ST_TOMB;
        else
            st = dht_pkg::ST_EMPTY;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        slot_next  = slot_reg;
        used_next  = used_reg;
        tomb_next  = tomb_reg;
        job_pop    = 1'b0;
        key_we     = 1'b0;
        unique case (state_reg)
            dht_pkg::BE_IDLE:
            begin
                if (job_ready)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    pos_next   = job.home;
                    cnt_next   = '0;
                    ok_next    = 1'b0;
                    slot_next  = '0;
                    state_next = (job.mode == dht_pkg::MODE_NONE) ?
                                 dht_pkg::BE_DONE : dht_pkg::BE_PROBE;
                end
            end
            dht_pkg::BE_PROBE:
            begin
                // Insert resolves on status alone; lookups wait for key read
                if (job_reg.mode == dht_pkg::MODE_INSERT)
                begin
                    if (st != dht_pkg::ST_KEY)
                    begin
                        key_we            = 1'b1;
                        used_next[pos_reg] = 1'b1;
                        tomb_next[pos_reg] = 1'b0;
                        ok_next           = 1'b1;
                        slot_next         = pos_reg;
                        state_next        = dht_pkg::BE_DONE;
                    end
                    else if (cnt_reg + (SW+1)'(1) >= job_reg.size)
                        state_next = dht_pkg::BE_DONE;
                    else
                    begin
                        cnt_next = cnt_reg + (SW+1)'(1);
                        pos_next = step_red[SW-1:0];
                    end
                end
                else if (st == dht_pkg::ST_EMPTY)
                    state_next = dht_pkg::BE_DONE;
                else
                    state_next = dht_pkg::BE_CHECK;
            end
            dht_pkg::BE_CHECK:
            begin
                if (st == dht_pkg::ST_KEY && rd_key_reg == job_reg.key)
                begin
                    if (job_reg.mode == dht_pkg::MODE_DELETE)
                    begin
                        used_next[pos_reg] = 1'b0;
                        tomb_next[pos_reg] = 1'b1;
                    end
                    ok_next    = 1'b1;
                    slot_next  = pos_reg;
                    state_next = dht_pkg::BE_DONE;
                end
                else if (cnt_reg + (SW+1)'(1) >= job_reg.size)
                    state_next = dht_pkg::BE_DONE;
                else
                begin
                    cnt_next   = cnt_reg + (SW+1)'(1);
                    pos_next   = step_red[SW-1:0];
                    state_next = dht_pkg::BE_PROBE;
                end
            end
            dht_pkg::BE_DONE:
            begin
                if (!out_stall)
                    state_next = dht_pkg::BE_IDLE;
            end
            default:
            begin
                state_next = dht_pkg::BE_IDLE;
            end
        endcase
    end

endmodule

[hdl/double_hash_table_top.sv]
// Flow: the front end computes the key remainder bit-serially (FE_MOD) and hands the
// job on in FE_PUSH; the back end pops it, then runs BE_PROBE for each insert probe
// or BE_PROBE and BE_CHECK for each search/delete probe (up to table size probes),
// then the result. The front end takes a new request once its job is pushed, while
// the back end still probes; a full queue or an output stall can hold requests off.
// Reset (rst_n, async low): table empty, table_size 11, queue clear, out_valid low.
module double_hash_table_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dht_pkg::MODE_W-1:0]     mode,
    input  logic [dht_pkg::KEY_W-1:0]      key,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [dht_pkg::SLOT_W-1:0]     slot,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [dht_pkg::SIZE_W-1:0] size_reg;
    logic job_valid, q_full, q_ready, q_pop;
    dht_pkg::job_t fe_job, q_job;

    // Hold the size register
    assign pready = 1'b1;
    assign prdata = (paddr == dht_pkg::ADDR_TABLE_SIZE) ? {27'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= dht_pkg::SIZE_RESET;
        else if (psel && penable && pwrite && paddr == dht_pkg::ADDR_TABLE_SIZE)
            size_reg <= pwdata[dht_pkg::SIZE_W-1:0];
    end

    dht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .table_size (size_reg),
        .job_valid  (job_valid),
        .job_full   (q_full),
        .job        (fe_job)
    );

    dht_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (fe_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ready),
        .pop_data  (q_job)
    );

    dht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_ready (q_ready),
        .job       (q_job),
        .job_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .slot      (slot)
    );

endmodule

[tb/testbench.sv]
class hash_scoreboard;
    int unsigned        tbl_size;
    logic [30:0]        stored_key [dht_pkg::MAX_SLOTS];
    dht_pkg::status_t   stored_st [dht_pkg::MAX_SLOTS];
    logic               ok_q [$];
    logic [3:0]         slot_q [$];
    int                 errors;
    int                 checked;

    function new();
        tbl_size = dht_pkg::SIZE_RESET;
        for (int i = 0; i < dht_pkg::MAX_SLOTS; i++)
        begin
            stored_key[i] = '0;
            stored_st[i] = dht_pkg::ST_EMPTY;
        end
        errors = 0;
        checked = 0;
    endfunction

    function int unsigned used_size();
        if (tbl_size < 2)
            return 2;
        if (tbl_size > dht_pkg::MAX_SLOTS)
            return dht_pkg::MAX_SLOTS;
        return tbl_size;
    endfunction

    // Print one mismatch line and count it
    task report(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    // Apply one request to the shadow table and queue its expected result
    function void note_request(dht_pkg::mode_t m, logic [30:0] k);
        int unsigned sz;
        int unsigned home;
        int unsigned stride;
        int unsigned s;
        logic        hit;
        logic [3:0]  where;
        sz = used_size();
        home = k % sz;
        stride = 8 - (k % 8);
        hit = 0;
        where = 0;
        for (int unsigned i = 0; i < sz; i++)
        begin
            s = (home + i * stride) % sz;
            if (m == dht_pkg::MODE_INSERT)
            begin
                if (stored_st[s] != dht_pkg::ST_KEY)
                begin
                    stored_key[s] = k;
                    stored_st[s] = dht_pkg::ST_KEY;
                    hit = 1;
                    where = 4'(s);
                    break;
                end
            end
            else if (m == dht_pkg::MODE_SEARCH || m == dht_pkg::MODE_DELETE)
            begin
                if (stored_st[s] == dht_pkg::ST_EMPTY)
                    break;
                if (stored_st[s] == dht_pkg::ST_KEY && stored_key[s] == k)
                begin
                    if (m == dht_pkg::MODE_DELETE)
                        stored_st[s] = dht_pkg::ST_TOMB;
                    hit = 1;
                    where = 4'(s);
                    break;
                end
            end
            else
                break;
        end
        ok_q.push_back(hit);
        slot_q.push_back(where);
    endfunction

    task check_result(input logic got_ok, input logic [3:0] got_slot);
        logic       exp_ok;
        logic [3:0] exp_slot;
        checked++;
        if (ok_q.size() == 0)
        begin
            report($sformatf("unexpected result ok=%0d slot=%0d", got_ok, got_slot));
            return;
        end
        exp_ok = ok_q.pop_front();
        exp_slot = slot_q.pop_front();
        if (got_ok !== exp_ok)
            report($sformatf("result %0d ok=%0d expected %0d", checked, got_ok, exp_ok));
        if (got_slot !== exp_slot)
            report($sformatf("result %0d slot=%0d expected %0d", checked, got_slot,
                             exp_slot));
    endtask
endclass

module testbench;
    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [dht_pkg::MODE_W-1:0]    mode;
    logic [dht_pkg::KEY_W-1:0]     key;
    logic                          out_valid;
    logic                          out_stall;
    logic                          ok;
    logic [dht_pkg::SLOT_W-1:0]    slot;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [1:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    hash_scoreboard        table_model;
    int                    send_idle_pct;
    int                    stall_pct;
    int                    requests_sent;
    longint                cycle_count;
    logic [30:0]           key_pool [$];

    localparam longint CYCLE_LIMIT = 3000000;

    double_hash_table_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .key      (key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok       (ok),
        .slot     (slot),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive random stall and check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                table_model.check_result(ok, slot);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_size(input logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= dht_pkg::ADDR_TABLE_SIZE;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        table_model.tbl_size = val[4:0];
    endtask

    // Present one request and hold it until accepted
    task automatic send_request(input dht_pkg::mode_t m, input logic [30:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
            in_valid <= 0;
        end
        @(posedge clk);
        in_valid <= 1;
        mode <= m;
        key <= k;
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 0;
        table_model.note_request(m, k);
        requests_sent++;
    endtask

    // Wait for all results, then let the block settle
    task automatic drain();
        while (table_model.ok_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [30:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(99) < 70)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return 31'($urandom_range(31'h7fffffff));
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        logic [30:0]     k;
        int              r;
        dht_pkg::mode_t  m;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            m = (r < 40) ? dht_pkg::MODE_INSERT : (r < 70) ? dht_pkg::MODE_SEARCH
                : (r < 97) ? dht_pkg::MODE_DELETE : dht_pkg::MODE_NONE;
            k = pick_key();
            if (key_pool.size() < 24)
                key_pool.push_back(k);
            else
                key_pool[$urandom_range(23)] = k;
            send_request(m, k);
        end
        drain();
    endtask

    initial
    begin
        table_model = new();
        cycle_count = 0;
        requests_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 0;
        in_valid = 0;
        mode = dht_pkg::MODE_INSERT;
        key = '0;
        out_stall = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Directed: extremes of key, all modes, duplicates, fill until full
        send_request(dht_pkg::MODE_INSERT, 31'h7fffffff);
        send_request(dht_pkg::MODE_INSERT, 31'd0);
        send_request(dht_pkg::MODE_INSERT, 31'd1);
        send_request(dht_pkg::MODE_INSERT, 31'd1);
        send_request(dht_pkg::MODE_SEARCH, 31'd1);
        send_request(dht_pkg::MODE_SEARCH, 31'h7fffffff);
        send_request(dht_pkg::MODE_SEARCH, 31'd12345);
        send_request(dht_pkg::MODE_DELETE, 31'd1);
        send_request(dht_pkg::MODE_SEARCH, 31'd1);
        send_request(dht_pkg::MODE_DELETE, 31'd999);
        send_request(dht_pkg::MODE_NONE, 31'h55555555);
        send_request(dht_pkg::MODE_NONE, 31'h2aaaaaaa);
        for (int i = 0; i < 11; i++)
            send_request(dht_pkg::MODE_INSERT, 31'(8 * i + 3));
        send_request(dht_pkg::MODE_SEARCH, 31'd2);
        drain();

        // Small table that wraps its probes, then the out-of-range sizes
        write_size(32'd2);
        random_phase(150, 0, 0);
        write_size(32'd0);
        random_phase(100, 48, 0);
        write_size(32'd31);
        random_phase(150, 0, 48);
        write_size(32'd16);
        random_phase(200, 29, 29);
        write_size(32'd7);
        random_phase(150, 48, 0);
        write_size(32'd1);
        random_phase(80, 0, 0);
        write_size(32'd13);
        random_phase(150, 0, 48);
        write_size(32'd11);
        random_phase(150, 29, 29);

        $display("Sent %0d requests over table sizes 0..31, checked %0d results",
                 requests_sent, table_model.checked);
        if (table_model.errors == 0 && table_model.ok_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
